@@ hdl/fed_pkg.sv @@
package fed_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 2'd2;

  localparam logic [14:0] FB_MAX    = 15'd31129;
  localparam logic [15:0] LEVEL_MAX = 16'd32768;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = 3;

  typedef struct packed {
    logic               vld;
    logic               in_range;
    logic               chan;
    logic               filled;
    logic signed [15:0] sample;
  } fed_tag_t;

  typedef struct packed {
    logic               chan;
    logic signed [15:0] sample;
  } fed_res_t;

endpackage

@@ hdl/fed_ram.sv @@
module fed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fed_mix.sv @@
module fed_mix #(
  parameter int AW = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  fed_pkg::fed_tag_t  p_tag,
  input  logic [AW-1:0]      p_raddr,
  input  logic [AW-1:0]      p_waddr,
  input  logic [14:0]        fb,
  input  logic [15:0]        lv,
  input  logic signed [15:0] rdata,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic signed [15:0] ram_wdata,
  output logic               res_valid,
  output fed_pkg::fed_res_t  res
);
  import fed_pkg::*;

  fed_tag_t           m_tag;
  fed_tag_t           w_tag;
  logic [AW-1:0]      m_waddr;
  logic [AW-1:0]      w_waddr;
  logic               m_fwd;
  logic signed [15:0] m_fwd_data;
  logic signed [15:0] delayed;
  logic signed [31:0] dl_w;
  logic signed [31:0] fb_w;
  logic signed [31:0] lv_w;
  logic signed [31:0] w_pfb;
  logic signed [31:0] w_plv;

  function automatic logic signed [15:0] mix_sat(input logic signed [15:0] x,
                                                 input logic signed [31:0] p);
    logic signed [33:0] s;
    logic signed [18:0] q;
    s = (34'(x) <<< 15) + 34'(p) + 34'sd16384;
    q = 19'(s >>> 15);
    if (q > 19'sd32767) begin
      return 16'sh7fff;
    end else if (q < -19'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tag <= '0;
      w_tag <= '0;
    end else begin
      m_tag <= p_tag;
      w_tag <= m_tag;
    end
  end

  // forward a write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    m_waddr    <= p_waddr;
    m_fwd      <= ram_we && (ram_waddr == p_raddr);
    m_fwd_data <= ram_wdata;
    w_waddr    <= m_waddr;
    w_pfb      <= dl_w * fb_w;
    w_plv      <= dl_w * lv_w;
  end

  always_comb begin
    if (!m_tag.filled) begin
      delayed = '0;
    end else if (m_fwd) begin
      delayed = m_fwd_data;
    end else begin
      delayed = rdata;
    end
    dl_w = 32'(delayed);
    fb_w = {17'd0, fb};
    lv_w = {16'd0, lv};
  end

  assign ram_we     = w_tag.vld && w_tag.in_range;
  assign ram_waddr  = w_waddr;
  assign ram_wdata  = mix_sat(w_tag.sample, w_pfb);
  assign res_valid  = w_tag.vld;
  assign res.chan   = w_tag.chan;
  assign res.sample = w_tag.in_range ? mix_sat(w_tag.sample, w_plv) : w_tag.sample;

endmodule

@@ hdl/fed_oq.sv @@
module fed_oq (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              push,
  input  fed_pkg::fed_res_t push_data,
  input  logic              out_ready,
  output logic              out_valid,
  output fed_pkg::fed_res_t out_data,
  output logic              room
);
  import fed_pkg::*;

  fed_res_t         q [OQ_DEPTH];
  logic [OQ_AW:0]   wr_ptr;
  logic [OQ_AW:0]   rd_ptr;
  logic [OQ_AW:0]   count;
  logic [OQ_AW:0]   occ;
  logic             pop;

  assign occ       = wr_ptr - rd_ptr;
  assign out_valid = (wr_ptr != rd_ptr);
  assign out_data  = q[rd_ptr[OQ_AW-1:0]];
  assign pop       = out_valid && out_ready;
  assign room      = (count != (OQ_AW+1)'(OQ_DEPTH));

  // count holds requests accepted and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (OQ_AW+1)'(take) - (OQ_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr[OQ_AW-1:0]] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (occ != (OQ_AW+1)'(OQ_DEPTH)))
    else $error("output queue overflow");

  a_empty_credit: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !out_valid)
    else $error("result without an outstanding request");

  a_occ_le_count: assert property (@(posedge clk) disable iff (rst)
    occ <= count)
    else $error("queue holds more than outstanding requests");
`endif

endmodule

@@ hdl/feedback_echo_delay_top.sv @@
// Per-channel feedback echo over one ring memory of CHANNELS x RING_LEN 16-bit
// entries. Each request reads the entry delay_samples (capped at RING_LEN) behind
// its channel's write position, writes back sample_in + delayed * feedback_gain
// and returns sample_in + delayed * mix_level, gains in units of 2^-15 and both
// results rounded and saturated to 16 bits. A request enters every cycle while
// the output queue has room; when delay_samples is 1, a request waits while the
// previous one is in the p stage, so its read meets that request's write-back.
// Results leave through an eight-entry output queue, which lets up to eight
// requests be outstanding. Entries never written since reset read as zero through
// per-channel fill tracking, so no clearing pass runs and requests are taken
// right after reset. Write configuration only while no request is outstanding.
module feedback_echo_delay_top #(
  parameter int RING_LEN = 131072,
  parameter int CHANNELS = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fed_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           chan,
  input  logic signed [15:0]             sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           chan_out,
  output logic signed [15:0]             sample_out
);
  import fed_pkg::*;

  localparam int RP_W   = $clog2(RING_LEN);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * (2 ** RP_W);
  localparam int RAM_AW = $clog2(DEPTH);
  localparam int CW     = (RP_W + 1 > CFG_DATA_W) ? RP_W + 1 : CFG_DATA_W;

  logic [17:0]        delay_samples;
  logic [14:0]        feedback_gain;
  logic [15:0]        mix_level;
  logic [14:0]        fb;
  logic [15:0]        lv;
  logic [RP_W:0]      dly_sat;
  logic [RP_W:0]      lag;
  logic               d_one;

  logic [RP_W-1:0]    wp [CHANNELS];
  logic               wrapped [CHANNELS];
  logic               acc;
  logic               in_range;
  logic [CH_W-1:0]    ch_idx;
  logic [RP_W-1:0]    wp_cur;
  logic               wrap;
  logic [RP_W-1:0]    wp_inc;

  logic               p_vld;
  logic               p_in_range;
  logic               p_chan;
  logic signed [15:0] p_sample;
  logic [CH_W-1:0]    p_ch;
  logic [RP_W-1:0]    p_wp;
  logic               p_wrapped;
  logic [RP_W:0]      rp_sum;
  logic [RP_W:0]      rp_full;
  logic [RP_W-1:0]    rp;
  fed_tag_t           p_tag;
  logic [RAM_AW-1:0]  p_raddr;
  logic [RAM_AW-1:0]  p_waddr;

  logic               ram_we;
  logic [RAM_AW-1:0]  ram_waddr;
  logic signed [15:0] ram_wdata;
  logic signed [15:0] ram_rdata;
  logic               res_valid;
  fed_res_t           res;
  fed_res_t           oq_data;
  logic               room;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= '0;
      feedback_gain <= '0;
      mix_level     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELAY:    delay_samples <= cfg_data;
        CFG_FEEDBACK: feedback_gain <= cfg_data[14:0];
        CFG_LEVEL:    mix_level     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign fb      = (feedback_gain > FB_MAX) ? FB_MAX : feedback_gain;
  assign lv      = (mix_level > LEVEL_MAX) ? LEVEL_MAX : mix_level;
  assign dly_sat = (CW'(delay_samples) > CW'(RING_LEN)) ? (RP_W+1)'(RING_LEN)
                                                        : (RP_W+1)'(delay_samples);
  assign d_one   = (delay_samples == 18'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      lag <= (RP_W+1)'(RING_LEN);
    end else begin
      lag <= (RP_W+1)'(RING_LEN) - dly_sat;
    end
  end

  assign acc      = in_valid && in_ready;
  assign in_ready = room && !(p_vld && d_one);
  assign in_range = (int'(chan) < CHANNELS);
  assign ch_idx   = CH_W'(chan);
  assign wp_cur   = wp[ch_idx];
  assign wrap     = (wp_cur == RP_W'(RING_LEN - 1));
  assign wp_inc   = wrap ? '0 : wp_cur + 1'b1;

  // advance the channel's write position when an in-range request is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp[c]      <= '0;
        wrapped[c] <= 1'b0;
      end
    end else if (acc && in_range) begin
      wp[ch_idx] <= wp_inc;
      if (wrap) begin
        wrapped[ch_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= acc;
    end
  end

  always_ff @(posedge clk) begin
    p_in_range <= in_range;
    p_chan     <= chan;
    p_sample   <= sample_in;
    p_ch       <= ch_idx;
    p_wp       <= wp_cur;
    p_wrapped  <= wrapped[ch_idx];
  end

  assign rp_sum  = {1'b0, p_wp} + lag;
  assign rp_full = (rp_sum >= (RP_W+1)'(RING_LEN)) ? rp_sum - (RP_W+1)'(RING_LEN) : rp_sum;
  assign rp      = rp_full[RP_W-1:0];
  assign p_raddr = RAM_AW'({p_ch, rp});
  assign p_waddr = RAM_AW'({p_ch, p_wp});

  always_comb begin
    p_tag.vld      = p_vld;
    p_tag.in_range = p_in_range;
    p_tag.chan     = p_chan;
    p_tag.filled   = p_wrapped || (rp < p_wp);
    p_tag.sample   = p_sample;
  end

  fed_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (p_raddr),
    .rdata (ram_rdata)
  );

  fed_mix #(
    .AW (RAM_AW)
  ) u_mix (
    .clk       (clk),
    .rst       (rst),
    .p_tag     (p_tag),
    .p_raddr   (p_raddr),
    .p_waddr   (p_waddr),
    .fb        (fb),
    .lv        (lv),
    .rdata     (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  fed_oq u_oq (
    .clk       (clk),
    .rst       (rst),
    .take      (acc),
    .push      (res_valid),
    .push_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (oq_data),
    .room      (room)
  );

  assign chan_out   = oq_data.chan;
  assign sample_out = oq_data.sample;

`ifndef SYNTHESIS
  a_unit_delay_gap: assert property (@(posedge clk) disable iff (rst)
    (acc && d_one && !cfg_we) |=> !acc)
    else $error("unit delay request taken before previous write-back");
`endif

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fed_pkg::*;

  localparam int RING_LEN = 131072;
  localparam int CHANNELS = 2;
  localparam int N_DIR = 28;
  localparam int N_PHASES = 12;
  localparam int PHASE_ITEMS = 128;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   ch;
    logic signed [15:0]     smp;
    bit                     typed;
    logic signed [15:0]     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic chan = 1'b0;
  logic signed [15:0] sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic chan_out;
  logic signed [15:0] sample_out;

  bit signed [15:0] echo_mem [CHANNELS][RING_LEN];
  int wr_pos [CHANNELS];
  logic [17:0] dly_reg;
  logic [14:0] fb_reg;
  logic [15:0] lvl_reg;

  fed_res_t pending_echo_q [$];
  int err_count;
  int src_idle_pct;
  int sink_stall_pct;

  stim_row_t dir_tab [N_DIR] = '{
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sh7FFF,   1'b1, 16'sh7FFF},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sh8000,   1'b1, 16'sh8000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b1, 16'shFFFF,   1'b1, 16'shFFFF},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b1, 16'sh0000,   1'b1, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sh0001,   1'b1, 16'sh0001},
    '{ROW_CFG,    CFG_DELAY,    18'd1,       1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_CFG,    CFG_FEEDBACK, 18'h3FFFF,   1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_CFG,    CFG_LEVEL,    18'h3FFFF,   1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_CFG,    CFG_UNUSED,   18'h15555,   1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sh7FFF,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sh8000,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b1, 16'sh8000,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b1, 16'sh8000,   1'b0, 16'sh0000},
    '{ROW_CFG,    CFG_DELAY,    18'd131072,  1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sd12345,  1'b1, 16'sd12345},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b1, -16'sd4321,  1'b1, -16'sd4321},
    '{ROW_CFG,    CFG_DELAY,    18'h3FFFF,   1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, -16'sd7,     1'b1, -16'sd7},
    '{ROW_CFG,    CFG_DELAY,    18'd0,       1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b1, 16'sd100,    1'b1, 16'sd100},
    '{ROW_CFG,    CFG_DELAY,    18'd2,       1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_CFG,    CFG_FEEDBACK, 18'd16384,   1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_CFG,    CFG_LEVEL,    18'd16384,   1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sh0001,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'shFFFF,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sh0000,   1'b0, 16'sh0000},
    '{ROW_SAMPLE, CFG_DELAY,    18'd0,       1'b0, 16'sh0000,   1'b0, 16'sh0000}
  };

  feedback_echo_delay_top #(
    .RING_LEN(RING_LEN),
    .CHANNELS(CHANNELS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .chan(chan),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .chan_out(chan_out),
    .sample_out(sample_out)
  );

  always #10 clk = ~clk;

  function automatic logic signed [15:0] mix_round(logic signed [15:0] dry,
                                                   logic signed [15:0] wet, int gain);
    longint acc;
    acc = longint'(dry) * 32768 + longint'(wet) * gain + 16384;
    acc = acc >>> 15;
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc[15:0];
  endfunction

  function automatic fed_res_t echo_step(logic ch, logic signed [15:0] x);
    int d, fb, lv, wp, rp;
    logic signed [15:0] delayed;
    fed_res_t r;
    d = (dly_reg > RING_LEN) ? RING_LEN : int'(dly_reg);
    fb = (fb_reg > FB_MAX) ? int'(FB_MAX) : int'(fb_reg);
    lv = (lvl_reg > LEVEL_MAX) ? int'(LEVEL_MAX) : int'(lvl_reg);
    wp = wr_pos[ch];
    rp = wp + RING_LEN - d;
    if (rp >= RING_LEN) rp -= RING_LEN;
    delayed = echo_mem[ch][rp];
    echo_mem[ch][wp] = mix_round(x, delayed, fb);
    wr_pos[ch] = (wp + 1) % RING_LEN;
    r.chan = ch;
    r.sample = mix_round(x, delayed, lv);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_DELAY:    dly_reg = val[17:0];
      CFG_FEEDBACK: fb_reg = val[14:0];
      CFG_LEVEL:    lvl_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_echo_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic play_sample(logic ch, logic signed [15:0] x, bit typed,
                             logic signed [15:0] want);
    fed_res_t r;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    chan <= ch;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
    r = echo_step(ch, x);
    if (typed) r.sample = want;
    pending_echo_q.push_back(r);
  endtask

  task automatic check_result();
    fed_res_t want;
    if (pending_echo_q.size() == 0) begin
      report_mismatch("result with no request pending, sample_out", int'(sample_out), 0);
    end else begin
      want = pending_echo_q.pop_front();
      if (chan_out !== want.chan)
        report_mismatch("chan_out", int'(chan_out), int'(want.chan));
      if (sample_out !== want.sample)
        report_mismatch("sample_out", int'(sample_out), int'(want.sample));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    out_ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic signed [15:0] x;
    logic [CFG_DATA_W-1:0] d_val, fb_val, lv_val;
    dly_reg = '0;
    fb_reg = '0;
    lvl_reg = '0;
    err_count = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
        cfg_we <= 1'b0;
      end else begin
        play_sample(dir_tab[i].ch, dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      case ($urandom_range(7))
        0: d_val = '0;
        1: d_val = CFG_DATA_W'(1);
        2: d_val = CFG_DATA_W'(RING_LEN);
        3: d_val = CFG_DATA_W'(RING_LEN + 1 + $urandom_range(RING_LEN - 2));
        4: d_val = CFG_DATA_W'(RING_LEN - $urandom_range(8, 1));
        default: d_val = CFG_DATA_W'($urandom_range(48, 2));
      endcase
      case ($urandom_range(3))
        0: fb_val = CFG_DATA_W'(FB_MAX);
        1: fb_val = CFG_DATA_W'($urandom_range(32767, FB_MAX + 1));
        2: fb_val = CFG_DATA_W'($urandom_range((1 << CFG_DATA_W) - 1));
        default: fb_val = CFG_DATA_W'($urandom_range(FB_MAX));
      endcase
      case ($urandom_range(3))
        0: lv_val = CFG_DATA_W'(LEVEL_MAX);
        1: lv_val = CFG_DATA_W'($urandom_range(65535, LEVEL_MAX + 1));
        2: lv_val = CFG_DATA_W'($urandom_range((1 << CFG_DATA_W) - 1));
        default: lv_val = CFG_DATA_W'($urandom_range(LEVEL_MAX));
      endcase
      write_reg(CFG_DELAY, d_val);
      write_reg(CFG_FEEDBACK, fb_val);
      write_reg(CFG_LEVEL, lv_val);
      if ($urandom_range(2) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
        default: begin src_idle_pct = 15; sink_stall_pct = 15; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(9))
          0: x = 16'sh7FFF;
          1: x = 16'sh8000;
          2: x = 16'($urandom_range(64)) - 16'sd32;
          default: x = 16'($urandom);
        endcase
        play_sample(1'($urandom_range(1)), x, 1'b0, 16'sh0000);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
